// ===== rtl/sfpd_pkg.sv =====
`timescale 1ns / 1ps

package sfpd_pkg;

    // payload store depth default
    localparam int MAX_PAYLOAD_DEF = 32;

    // crc-16 ccitt constants
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam int          CRC_BITS = 8;

    // configuration register indexes
    localparam logic [1:0] REG_FIRST_SYNC  = 2'd0;
    localparam logic [1:0] REG_SECOND_SYNC = 2'd1;
    localparam logic [1:0] REG_MAX_LENGTH  = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_HEADER    = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD   = 2'd1;
    localparam logic [1:0] KIND_CRC_ERROR = 2'd2;

    // control from the parser to the crc unit
    typedef struct packed {
        logic       restart;
        logic       load;
        logic [7:0] data;
    } crc_ctrl_t;

endpackage

// ===== rtl/sfpd_ram.sv =====
`timescale 1ns / 1ps

module sfpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

// ===== rtl/sfpd_crc_unit.sv =====
`timescale 1ns / 1ps

module sfpd_crc_unit
    import sfpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  crc_ctrl_t   ctrl,
    output logic [15:0] crc,
    output logic        busy
);

    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [3:0]  cnt_reg;
    logic [3:0]  cnt_next;

    // one polynomial step per cycle, eight steps per byte
    always_comb
    begin
        crc_next = crc_reg;
        cnt_next = cnt_reg;
        if (ctrl.restart)
        begin
            crc_next = CRC_INIT;
        end
        else if (ctrl.load)
        begin
            crc_next = crc_reg ^ {ctrl.data, 8'h00};
            cnt_next = 4'(CRC_BITS);
        end
        else if (cnt_reg != 4'd0)
        begin
            crc_next = crc_reg[15] ? ({crc_reg[14:0], 1'b0} ^ CRC_POLY)
                                   : {crc_reg[14:0], 1'b0};
            cnt_next = cnt_reg - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= CRC_INIT;
            cnt_reg <= 4'd0;
        end
        else
        begin
            crc_reg <= crc_next;
            cnt_reg <= cnt_next;
        end
    end

    assign crc  = crc_reg;
    assign busy = (cnt_reg != 4'd0);

endmodule

// ===== rtl/sync_framed_packet_deframer_crc16.sv =====
`timescale 1ns / 1ps

// Byte-stream deframer for frames laid out as first sync, second sync, id,
// length, payload and a little-endian CRC-16/CCITT-FALSE over id, length and
// payload. Id, length and payload bytes each pass through the single CRC unit,
// which shifts one bit per cycle, and the input is held off until it is done.
// After the last CRC byte a good frame emits a header result and then replays
// each payload byte from the payload RAM with a read state and then a load
// state, the last result carrying tlast; a bad CRC emits one checksum-error
// result. While results are replayed no input byte is taken, and output stalls
// hold up the replay.
module sync_framed_packet_deframer_crc16
    import sfpd_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] frame_id, [13:8] frame_length,
                                        // [21:14] data_byte, [23:22] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] item_kind
    output logic        m_axis_tlast,
    // configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata
);

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam logic [5:0] LIMIT_CAP = 6'(MAX_PAYLOAD);

    // parser phases
    localparam logic [2:0] PH_SYNC1 = 3'd0;
    localparam logic [2:0] PH_SYNC2 = 3'd1;
    localparam logic [2:0] PH_ID    = 3'd2;
    localparam logic [2:0] PH_LEN   = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;
    localparam logic [2:0] PH_CRCLO = 3'd5;
    localparam logic [2:0] PH_CRCHI = 3'd6;

    // sequencer states
    localparam logic [2:0] S_IN  = 3'd0;
    localparam logic [2:0] S_HDR = 3'd1;
    localparam logic [2:0] S_ERR = 3'd2;
    localparam logic [2:0] S_RD  = 3'd3;
    localparam logic [2:0] S_DAT = 3'd4;

    logic [7:0]  first_sync_reg;
    logic [7:0]  second_sync_reg;
    logic [5:0]  max_length_reg;

    logic [2:0]  state_reg,   state_next;
    logic [2:0]  phase_reg,   phase_next;
    logic [7:0]  held_id_reg, held_id_next;
    logic [5:0]  held_len_reg, held_len_next;
    logic [5:0]  index_reg,   index_next;
    logic [5:0]  rd_idx_reg,  rd_idx_next;
    logic [7:0]  crc_lo_reg,  crc_lo_next;

    logic        out_valid_reg, out_valid_next;
    logic [1:0]  out_kind_reg,  out_kind_next;
    logic [7:0]  out_data_reg,  out_data_next;
    logic        out_last_reg,  out_last_next;
    logic [7:0]  out_id_reg,    out_id_next;
    logic [5:0]  out_len_reg,   out_len_next;

    crc_ctrl_t   crc_ctrl;
    logic [15:0] crc_value;
    logic        crc_busy;

    logic        in_fire;
    logic        out_free;
    logic [5:0]  limit;
    logic        ram_we;
    logic [7:0]  ram_rdata;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_sync_reg  <= 8'hAA;
            second_sync_reg <= 8'h55;
            max_length_reg  <= 6'd32;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_FIRST_SYNC:  first_sync_reg  <= cfg_wdata;
                REG_SECOND_SYNC: second_sync_reg <= cfg_wdata;
                REG_MAX_LENGTH:  max_length_reg  <= cfg_wdata[5:0];
                default:         ;
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IN) && !crc_busy;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign limit         = (max_length_reg < LIMIT_CAP) ? max_length_reg : LIMIT_CAP;
    assign ram_we        = in_fire && (phase_reg == PH_DATA);

    // parser and result sequencer
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        held_id_next   = held_id_reg;
        held_len_next  = held_len_reg;
        index_next     = index_reg;
        rd_idx_next    = rd_idx_reg;
        crc_lo_next    = crc_lo_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_kind_next  = out_kind_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_id_next    = out_id_reg;
        out_len_next   = out_len_reg;
        crc_ctrl       = '0;
        crc_ctrl.data  = s_axis_tdata;

        unique case (state_reg)
            S_IN:
            begin
                if (in_fire)
                begin
                    unique case (phase_reg)
                        PH_SYNC1:
                        begin
                            if (s_axis_tdata == first_sync_reg)
                            begin
                                phase_next = PH_SYNC2;
                            end
                        end
                        PH_SYNC2:
                        begin
                            if (s_axis_tdata == second_sync_reg)
                            begin
                                phase_next       = PH_ID;
                                crc_ctrl.restart = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_SYNC1;
                            end
                        end
                        PH_ID:
                        begin
                            held_id_next  = s_axis_tdata;
                            crc_ctrl.load = 1'b1;
                            phase_next    = PH_LEN;
                        end
                        PH_LEN:
                        begin
                            if (s_axis_tdata > {2'b00, limit})
                            begin
                                phase_next = PH_SYNC1;
                            end
                            else
                            begin
                                held_len_next = s_axis_tdata[5:0];
                                crc_ctrl.load = 1'b1;
                                index_next    = 6'd0;
                                phase_next    = (s_axis_tdata == 8'd0) ? PH_CRCLO : PH_DATA;
                            end
                        end
                        PH_DATA:
                        begin
                            crc_ctrl.load = 1'b1;
                            index_next    = index_reg + 6'd1;
                            if (index_reg + 6'd1 >= held_len_reg)
                            begin
                                phase_next = PH_CRCLO;
                            end
                        end
                        PH_CRCLO:
                        begin
                            crc_lo_next = s_axis_tdata;
                            phase_next  = PH_CRCHI;
                        end
                        PH_CRCHI:
                        begin
                            phase_next = PH_SYNC1;
                            if ({s_axis_tdata, crc_lo_reg} == crc_value)
                            begin
                                state_next = S_HDR;
                            end
                            else
                            begin
                                state_next = S_ERR;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_SYNC1;
                        end
                    endcase
                end
            end
            S_HDR:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_HEADER;
                    out_data_next  = 8'd0;
                    out_last_next  = (held_len_reg == 6'd0);
                    out_id_next    = held_id_reg;
                    out_len_next   = held_len_reg;
                    rd_idx_next    = 6'd0;
                    state_next     = (held_len_reg == 6'd0) ? S_IN : S_RD;
                end
            end
            S_ERR:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_CRC_ERROR;
                    out_data_next  = 8'd0;
                    out_last_next  = 1'b1;
                    out_id_next    = held_id_reg;
                    out_len_next   = held_len_reg;
                    state_next     = S_IN;
                end
            end
            S_RD:
            begin
                // read address settles, data registered for the next cycle
                state_next = S_DAT;
            end
            S_DAT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_PAYLOAD;
                    out_data_next  = ram_rdata;
                    out_last_next  = (rd_idx_reg + 6'd1 == held_len_reg);
                    out_id_next    = held_id_reg;
                    out_len_next   = held_len_reg;
                    rd_idx_next    = rd_idx_reg + 6'd1;
                    state_next     = (rd_idx_reg + 6'd1 == held_len_reg) ? S_IN : S_RD;
                end
            end
            default:
            begin
                state_next = S_IN;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IN;
            phase_reg     <= PH_SYNC1;
            held_id_reg   <= 8'd0;
            held_len_reg  <= 6'd0;
            index_reg     <= 6'd0;
            rd_idx_reg    <= 6'd0;
            crc_lo_reg    <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            held_id_reg   <= held_id_next;
            held_len_reg  <= held_len_next;
            index_reg     <= index_next;
            rd_idx_reg    <= rd_idx_next;
            crc_lo_reg    <= crc_lo_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload registers
    always_ff @(posedge clk)
    begin
        out_kind_reg <= out_kind_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_id_reg   <= out_id_next;
        out_len_reg  <= out_len_next;
    end

    // shared bit-serial crc unit
    sfpd_crc_unit u_crc (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (crc_ctrl),
        .crc   (crc_value),
        .busy  (crc_busy)
    );

    // payload store
    sfpd_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (index_reg[AW-1:0]),
        .wdata (s_axis_tdata),
        .raddr (rd_idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_data_reg, out_len_reg, out_id_reg};
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import sfpd_pkg::*;

    // parser phases of the frame predictor
    typedef enum logic [2:0] {
        PH_HUNT,
        PH_SYNC2,
        PH_ID,
        PH_LEN,
        PH_DATA,
        PH_CRC_LO,
        PH_CRC_HI
    } parse_phase_e;

    // ways a generated frame can be broken
    typedef enum logic [1:0] {
        FLAW_NONE,
        FLAW_BAD_CRC,
        FLAW_SYNC2,
        FLAW_TOO_LONG
    } frame_flaw_e;

    // one result transaction: kind, id, length, data byte and last
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] id;
        logic [5:0] length;
        logic [7:0] data;
        logic       last;
    } deframe_result_t;

    // frame predictor and result checker
    class frame_scoreboard;
        logic [7:0]      sync_a;
        logic [7:0]      sync_b;
        logic [5:0]      len_limit;
        parse_phase_e    ph;
        logic [7:0]      id_r;
        logic [5:0]      len_r;
        int              idx;
        logic [15:0]     crc;
        logic [7:0]      crc_lo;
        logic [7:0]      store [MAX_PAYLOAD_DEF];
        deframe_result_t pending_results[$];
        int              fail_count;
        int              checked_count;

        function new();
            sync_a        = 8'hAA;
            sync_b        = 8'h55;
            len_limit     = 6'd32;
            ph            = PH_HUNT;
            id_r          = 8'h00;
            len_r         = 6'd0;
            idx           = 0;
            crc           = CRC_INIT;
            crc_lo        = 8'h00;
            fail_count    = 0;
            checked_count = 0;
        endfunction

        // crc-16 ccitt, msb first, one byte
        function logic [15:0] crc16_byte(logic [15:0] c_in, logic [7:0] b);
            logic [15:0] c;
            c = c_in ^ {b, 8'h00};
            repeat (CRC_BITS) c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
            return c;
        endfunction

        function int len_cap();
            return (len_limit < MAX_PAYLOAD_DEF) ? int'(len_limit) : MAX_PAYLOAD_DEF;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void set_reg(logic [1:0] idx_w, logic [7:0] val);
            case (idx_w)
                REG_FIRST_SYNC:  sync_a = val;
                REG_SECOND_SYNC: sync_b = val;
                REG_MAX_LENGTH:  len_limit = val[5:0];
                default:         ;
            endcase
        endfunction

        function void push_result(logic [1:0] kind, logic [7:0] data, logic last);
            deframe_result_t r;
            r.kind   = kind;
            r.id     = id_r;
            r.length = len_r;
            r.data   = data;
            r.last   = last;
            pending_results.push_back(r);
        endfunction

        // advance the parser by one accepted byte
        function void note_rx_byte(logic [7:0] b);
            int i;
            case (ph)
                PH_HUNT:
                    if (b == sync_a) ph = PH_SYNC2;
                PH_SYNC2:
                begin
                    if (b == sync_b)
                    begin
                        ph  = PH_ID;
                        crc = CRC_INIT;
                    end
                    else
                    begin
                        ph = PH_HUNT;
                    end
                end
                PH_ID:
                begin
                    id_r = b;
                    crc  = crc16_byte(crc, b);
                    ph   = PH_LEN;
                end
                PH_LEN:
                begin
                    if (int'(b) > len_cap())
                    begin
                        ph = PH_HUNT;
                    end
                    else
                    begin
                        len_r = b[5:0];
                        crc   = crc16_byte(crc, b);
                        idx   = 0;
                        ph    = (b == 8'h00) ? PH_CRC_LO : PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    store[idx] = b;
                    crc        = crc16_byte(crc, b);
                    idx++;
                    if (idx >= len_r) ph = PH_CRC_LO;
                end
                PH_CRC_LO:
                begin
                    crc_lo = b;
                    ph     = PH_CRC_HI;
                end
                PH_CRC_HI:
                begin
                    ph = PH_HUNT;
                    if ({b, crc_lo} == crc)
                    begin
                        push_result(KIND_HEADER, 8'h00, len_r == 6'd0);
                        for (i = 0; i < len_r; i++)
                            push_result(KIND_PAYLOAD, store[i], (i + 1) == len_r);
                    end
                    else
                    begin
                        push_result(KIND_CRC_ERROR, 8'h00, 1'b1);
                    end
                end
                default:
                    ph = PH_HUNT;
            endcase
        endfunction

        function void mismatch(string field, int unsigned want_v, int unsigned got_v);
            fail_count++;
            if (fail_count <= 100)
                $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want_v, got_v);
        endfunction

        // compare one result transaction with the oldest prediction
        function void check_result(deframe_result_t got);
            deframe_result_t want;
            checked_count++;
            if (pending_results.size() == 0)
            begin
                fail_count++;
                $error("unexpected result transaction: kind %0d id 0x%0h", got.kind, got.id);
                return;
            end
            want = pending_results.pop_front();
            if (got.kind !== want.kind)     mismatch("item_kind", want.kind, got.kind);
            if (got.id !== want.id)         mismatch("frame_id", want.id, got.id);
            if (got.length !== want.length) mismatch("frame_length", want.length, got.length);
            if (got.data !== want.data)     mismatch("data_byte", want.data, got.data);
            if (got.last !== want.last)     mismatch("last", want.last, got.last);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [7:0]  cfg_wdata;

    frame_scoreboard sb = new();
    deframe_result_t out_item;
    logic [7:0]      frame_body[$];
    int              burst_left;
    bit              sender_bursty;
    bit              hold_off_req;
    int              bytes_sent;
    int              frames_good;
    int              frames_bad;
    int              frames_dropped;
    int              configs_run;

    sync_framed_packet_deframer_crc16 i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // result fields as the predictor orders them
    assign out_item = {m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[13:8],
                       m_axis_tdata[21:14], m_axis_tlast};

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(out_item);
    end

    // receiver: rotating stall patterns, plus a long hold-off on request
    initial
    begin
        int cyc;
        int stall_mode;
        cyc           = 0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                // longer than a full-length frame takes to arrive
                m_axis_tready <= 1'b0;
                repeat (800) @(negedge clk);
                hold_off_req = 1'b0;
            end
            else
            begin
                cyc++;
                stall_mode = (cyc / 50) % 4;
                case (stall_mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    2:       m_axis_tready <= (cyc % 5) != 0;
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // one byte transaction, with bursty gaps in front when enabled
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            if (sender_bursty && $urandom_range(0, 3) != 0)
            begin
                gap = $urandom_range(1, 6);
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_rx_byte(b);
        bytes_sent++;
        @(negedge clk);
    endtask

    // stop sending until every predicted result has come, then let the crc unit settle
    task automatic wait_for_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        burst_left = 0;
    endtask

    task automatic write_reg(input logic [1:0] idx_w, input logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx_w;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        sb.set_reg(idx_w, val);
    endtask

    task automatic set_framing(input logic [7:0] s1, input logic [7:0] s2,
                               input logic [5:0] max_len);
        wait_for_idle();
        write_reg(REG_FIRST_SYNC, s1);
        write_reg(REG_SECOND_SYNC, s2);
        write_reg(REG_MAX_LENGTH, {2'b00, max_len});
        configs_run++;
    endtask

    function automatic void fill_body(input int len);
        frame_body.delete();
        repeat (len) frame_body.push_back(8'($urandom_range(0, 255)));
    endfunction

    // mostly short payloads, sometimes any length up to the cap, sometimes the cap
    function automatic int pick_length(input int cap);
        int r;
        if (cap == 0) return 0;
        r = $urandom_range(0, 9);
        if (r == 0) return cap;
        if (r < 3) return $urandom_range(0, cap);
        return $urandom_range(0, (cap < 6) ? cap : 6);
    endfunction

    // one frame from the current sync bytes and frame_body
    task automatic send_frame(input logic [7:0] id, input int len, input frame_flaw_e flaw);
        logic [15:0] crc;
        int          i;
        send_byte(sb.sync_a);
        if (flaw == FLAW_SYNC2)
        begin
            send_byte(sb.sync_b ^ 8'($urandom_range(1, 255)));
            frames_dropped++;
            return;
        end
        send_byte(sb.sync_b);
        send_byte(id);
        send_byte(len[7:0]);
        if (flaw == FLAW_TOO_LONG)
        begin
            frames_dropped++;
            return;
        end
        crc = sb.crc16_byte(CRC_INIT, id);
        crc = sb.crc16_byte(crc, len[7:0]);
        for (i = 0; i < len; i++)
        begin
            send_byte(frame_body[i]);
            crc = sb.crc16_byte(crc, frame_body[i]);
        end
        if (flaw == FLAW_BAD_CRC)
        begin
            crc = crc ^ (16'h0001 << $urandom_range(0, 15));
            frames_bad++;
        end
        else
        begin
            frames_good++;
        end
        send_byte(crc[7:0]);
        send_byte(crc[15:8]);
    endtask

    // line noise that never starts a frame
    task automatic send_noise(input int n);
        logic [7:0] b;
        repeat (n)
        begin
            b = 8'($urandom_range(0, 255));
            if (b == sb.sync_a) b = ~b;
            send_byte(b);
        end
    endtask

    // random mix: mostly good frames, some broken frames, noise and pauses
    task automatic run_random(input int budget);
        int start;
        int pick;
        int cap;
        int len;
        start = bytes_sent;
        while (bytes_sent - start < budget)
        begin
            pick = $urandom_range(0, 99);
            cap  = sb.len_cap();
            if (pick < 78)
            begin
                len = pick_length(cap);
                fill_body(len);
                send_frame(8'($urandom_range(0, 255)), len,
                           (pick < 68) ? FLAW_NONE : FLAW_BAD_CRC);
            end
            else if (pick < 86)
                send_frame(8'($urandom_range(0, 255)), $urandom_range(cap + 1, 255),
                           FLAW_TOO_LONG);
            else if (pick < 93)
                send_frame(8'h00, 0, FLAW_SYNC2);
            else if (pick < 97)
                send_noise($urandom_range(1, 3));
            else
                wait_for_idle();
        end
    endtask

    // stimulus
    initial
    begin
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = 8'h00;
        cfg_we         = 1'b0;
        cfg_addr       = REG_FIRST_SYNC;
        cfg_wdata      = 8'h00;
        burst_left     = 0;
        sender_bursty  = 1'b0;
        hold_off_req   = 1'b0;
        bytes_sent     = 0;
        frames_good    = 0;
        frames_bad     = 0;
        frames_dropped = 0;
        configs_run    = 1;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: zero length, byte extremes, sync2 miss, bad crc, oversize length
        frame_body.delete();
        send_frame(8'hFF, 0, FLAW_NONE);
        frame_body = '{8'h00, 8'hFF};
        send_frame(8'h00, 2, FLAW_NONE);
        // sync2 miss on a first-sync value must not restart the frame
        send_byte(sb.sync_a);
        send_byte(sb.sync_a);
        send_byte(sb.sync_b);
        frames_dropped++;
        fill_body(1);
        send_frame(8'h5A, 1, FLAW_BAD_CRC);
        send_frame(8'h3C, 33, FLAW_TOO_LONG);

        sender_bursty = 1'b1;
        run_random(10);

        // zero length limit, sender without gaps
        set_framing(8'h00, 8'hFF, 6'd0);
        sender_bursty = 1'b0;
        run_random(15);
        sender_bursty = 1'b1;

        // full length frame against a long receiver hold-off
        set_framing(8'hFF, 8'h00, 6'd32);
        hold_off_req = 1'b1;
        fill_body(32);
        send_frame(8'($urandom_range(0, 255)), 32, FLAW_NONE);
        run_random(15);

        set_framing(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    6'($urandom_range(1, 31)));
        run_random(20);

        set_framing(8'hAA, 8'h55, 6'd32);
        run_random(20);

        wait_for_idle();
        if (sb.pending() != 0)
        begin
            $error("%0d predicted results never arrived", sb.pending());
            sb.fail_count++;
        end
        $display("run covered %0d bytes: %0d good frames, %0d bad-crc frames, %0d dropped",
                 bytes_sent, frames_good, frames_bad, frames_dropped);
        $display("%0d result transactions checked over %0d framing setups, %0d mismatches",
                 sb.checked_count, configs_run, sb.fail_count);
        if (sb.fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/sfpd_pkg.sv
rtl/sfpd_ram.sv
rtl/sfpd_crc_unit.sv
rtl/sync_framed_packet_deframer_crc16.sv
tb/tb_top.sv
